// ----- hw/rtl/json_token_scanner_defines.svh -----
// Assertion macros for the JSON token scanner RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef JSON_TOKEN_SCANNER_DEFINES_SVH
`define JSON_TOKEN_SCANNER_DEFINES_SVH
`ifndef SYNTHESIS
`define JTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define JTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define JTS_ASSERT(lbl, prop, msg)
`define JTS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/jts_pkg.sv -----
// Shared types, codes and helper functions for the JSON token scanner.
// No dependencies; used by all jts_* modules and the top level.
package jts_pkg;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int OQ_DEPTH    = 4;
    localparam logic [6:0] MAX_LENGTH_RST = 7'd64;
    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

    // scan phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_QFIRST = 3'd2;
    localparam logic [2:0] PH_QSTR   = 3'd3;
    localparam logic [2:0] PH_ESC    = 3'd4;
    localparam logic [2:0] PH_HEX    = 3'd5;
    localparam logic [2:0] PH_WORD   = 3'd6;

    // token kinds
    localparam logic [2:0] KIND_QUOTED = 3'd0;
    localparam logic [2:0] KIND_WORD   = 3'd1;
    localparam logic [2:0] KIND_OBJECT = 3'd2;
    localparam logic [2:0] KIND_ARRAY  = 3'd3;
    localparam logic [2:0] KIND_EMPTY  = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_HIGH     = 8'h80;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_B        = 8'h62;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CC_BS       = 8'h08;
    localparam logic [7:0] CC_TAB      = 8'h09;
    localparam logic [7:0] CC_LF       = 8'h0A;
    localparam logic [7:0] CC_FF       = 8'h0C;
    localparam logic [7:0] CC_CR       = 8'h0D;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       scan_done;
        logic [2:0] token_kind;
        logic       end_consumed;
    } t_result;

    // max_length above 64 acts as 64; 0 and 1 give no characters
    function automatic logic [5:0] char_limit(input logic [6:0] m);
        logic [5:0] lim;
        if (m[6]) begin
            lim = 6'd63;
        end else if (m == 7'd0) begin
            lim = 6'd0;
        end else begin
            lim = 6'(m - 7'd1);
        end
        return lim;
    endfunction

    // loose hex digit: 0x41..0x4F and 0x61..0x6F map to 9 + low nibble
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c inside {[8'h30:8'h39]}) begin
            d = {1'b0, c[3:0]};
        end else if (c inside {[8'h41:8'h4F], [8'h61:8'h6F]}) begin
            d = 5'd9 + {1'b0, c[3:0]};
        end else begin
            d = 5'd0;
        end
        return d;
    endfunction

endpackage

// ----- hw/rtl/jts_regs.sv -----
// APB configuration register block: holds max_length.
// Depends on jts_pkg.
module jts_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jts_pkg::APB_AW-1:0]   paddr,
    input  logic [jts_pkg::APB_DW-1:0]   pwdata,
    output logic [jts_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [6:0]                   o_max_length
);
    logic [6:0] r_max_length;
    logic       wr_hit;
    logic       rd_hit;

    assign rd_hit = (paddr[jts_pkg::APB_AW-1:2] == jts_pkg::REG_MAX_LENGTH) && (paddr[1:0] == 2'b00);
    assign wr_hit = psel && penable && pwrite && rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= jts_pkg::MAX_LENGTH_RST;
        end else if (wr_hit) begin
            r_max_length <= pwdata[6:0];
        end
    end

    assign prdata       = rd_hit ? {{(jts_pkg::APB_DW-7){1'b0}}, r_max_length} : '0;
    assign pready       = 1'b1;
    assign o_max_length = r_max_length;
endmodule

// ----- hw/rtl/jts_core.sv -----
// Scanner core: input register, scan state and one-pass token decode.
// Depends on jts_pkg and json_token_scanner_defines.svh.
`include "json_token_scanner_defines.svh"
module jts_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [6:0]          i_max_length,
    input  logic                i_in_valid,
    input  logic [7:0]          i_in_byte,
    input  logic                i_in_start,
    output logic                o_busy,
    output logic                o_push,
    output jts_pkg::t_result    o_res
);
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic [2:0] r_phase;
    logic [5:0] r_cnt;
    logic [7:0] r_hv;
    logic [2:0] r_hs;

    logic [2:0] n_phase;
    logic [5:0] n_cnt;
    logic [7:0] n_hv;
    logic [2:0] n_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_in_start;
        end
    end

    always_comb begin
        logic [7:0]  b;
        logic [2:0]  ph;
        logic [5:0]  cnt;
        logic [5:0]  cnt_inc;
        logic [5:0]  lim;
        logic [7:0]  hv;
        logic [2:0]  hs;
        logic [7:0]  hv_sh;
        logic [2:0]  hs_inc;
        logic        word_end;
        logic        esc_hit;
        logic [7:0]  esc_ch;
        b        = r_in_byte;
        ph       = r_in_start ? jts_pkg::PH_SKIP : r_phase;
        cnt      = r_in_start ? 6'd0 : r_cnt;
        hv       = r_in_start ? 8'd0 : r_hv;
        hs       = r_in_start ? 3'd0 : r_hs;
        cnt_inc  = cnt + 6'd1;
        lim      = jts_pkg::char_limit(i_max_length);
        hv_sh    = 8'({hv[3:0], 4'h0} + {3'b000, jts_pkg::hex_digit(b)});
        hs_inc   = hs + 3'd1;
        word_end = (b <= jts_pkg::CH_SPACE) || (b >= jts_pkg::CH_HIGH)
                   || (b inside {jts_pkg::CH_COMMA, jts_pkg::CH_RBRACKET, jts_pkg::CH_RBRACE});
        esc_hit  = 1'b1;
        case (b)
            jts_pkg::CH_QUOTE:  esc_ch = jts_pkg::CH_QUOTE;
            jts_pkg::CH_BSLASH: esc_ch = jts_pkg::CH_BSLASH;
            jts_pkg::CH_SLASH:  esc_ch = jts_pkg::CH_SLASH;
            jts_pkg::CH_B:      esc_ch = jts_pkg::CC_BS;
            jts_pkg::CH_F:      esc_ch = jts_pkg::CC_FF;
            jts_pkg::CH_R:      esc_ch = jts_pkg::CC_CR;
            jts_pkg::CH_N:      esc_ch = jts_pkg::CC_LF;
            jts_pkg::CH_T:      esc_ch = jts_pkg::CC_TAB;
            default: begin
                esc_ch  = 8'd0;
                esc_hit = 1'b0;
            end
        endcase

        n_phase = ph;
        n_cnt   = cnt;
        n_hv    = hv;
        n_hs    = hs;
        o_push  = 1'b0;
        o_res   = '0;

        // a brace at the start of a scan, or after a first quote, is an object open
        if ((ph == jts_pkg::PH_SKIP || ph == jts_pkg::PH_QFIRST) && (b == jts_pkg::CH_LBRACE)) begin
            o_push           = 1'b1;
            o_res.scan_done  = 1'b1;
            o_res.token_kind = jts_pkg::KIND_OBJECT;
            n_phase          = jts_pkg::PH_IDLE;
        end else begin
            case (ph)
                jts_pkg::PH_SKIP: begin
                    if (b inside {[8'h01:jts_pkg::CH_SPACE]}) begin
                        n_phase = jts_pkg::PH_SKIP;
                    end else if (b == jts_pkg::CH_NUL) begin
                        o_push           = 1'b1;
                        o_res.scan_done  = 1'b1;
                        o_res.token_kind = jts_pkg::KIND_EMPTY;
                        n_phase          = jts_pkg::PH_IDLE;
                    end else if (b == jts_pkg::CH_LBRACKET) begin
                        o_push           = 1'b1;
                        o_res.scan_done  = 1'b1;
                        o_res.token_kind = jts_pkg::KIND_ARRAY;
                        n_phase          = jts_pkg::PH_IDLE;
                    end else if (b == jts_pkg::CH_QUOTE) begin
                        n_phase = jts_pkg::PH_QFIRST;
                    end else begin
                        // first byte of a bare word; a word end here gives an empty word
                        o_push = 1'b1;
                        if (word_end || cnt >= lim) begin
                            o_res.scan_done  = 1'b1;
                            o_res.token_kind = jts_pkg::KIND_WORD;
                            n_phase          = jts_pkg::PH_IDLE;
                        end else begin
                            n_cnt            = cnt_inc;
                            o_res.out_char   = b;
                            o_res.char_valid = 1'b1;
                            if (cnt_inc >= lim) begin
                                o_res.scan_done    = 1'b1;
                                o_res.token_kind   = jts_pkg::KIND_WORD;
                                o_res.end_consumed = 1'b1;
                                n_phase            = jts_pkg::PH_IDLE;
                            end else begin
                                n_phase = jts_pkg::PH_WORD;
                            end
                        end
                    end
                end
                jts_pkg::PH_WORD: begin
                    o_push = 1'b1;
                    if (word_end || cnt >= lim) begin
                        o_res.scan_done  = 1'b1;
                        o_res.token_kind = jts_pkg::KIND_WORD;
                        n_phase          = jts_pkg::PH_IDLE;
                    end else begin
                        n_cnt            = cnt_inc;
                        o_res.out_char   = b;
                        o_res.char_valid = 1'b1;
                        if (cnt_inc >= lim) begin
                            o_res.scan_done    = 1'b1;
                            o_res.token_kind   = jts_pkg::KIND_WORD;
                            o_res.end_consumed = 1'b1;
                            n_phase            = jts_pkg::PH_IDLE;
                        end
                    end
                end
                jts_pkg::PH_QFIRST, jts_pkg::PH_QSTR: begin
                    n_phase = jts_pkg::PH_QSTR;
                    if (b == jts_pkg::CH_QUOTE) begin
                        o_push             = 1'b1;
                        o_res.scan_done    = 1'b1;
                        o_res.end_consumed = 1'b1;
                        n_phase            = jts_pkg::PH_IDLE;
                    end else if (b == jts_pkg::CH_NUL || cnt >= lim) begin
                        o_push          = 1'b1;
                        o_res.scan_done = 1'b1;
                        n_phase         = jts_pkg::PH_IDLE;
                    end else if (b == jts_pkg::CH_BSLASH) begin
                        n_phase = jts_pkg::PH_ESC;
                    end else begin
                        o_push           = 1'b1;
                        o_res.out_char   = b;
                        o_res.char_valid = 1'b1;
                        n_cnt            = cnt_inc;
                    end
                end
                jts_pkg::PH_ESC: begin
                    n_phase = jts_pkg::PH_QSTR;
                    if (b == jts_pkg::CH_NUL) begin
                        o_push          = 1'b1;
                        o_res.scan_done = 1'b1;
                        n_phase         = jts_pkg::PH_IDLE;
                    end else if (b == jts_pkg::CH_U) begin
                        n_phase = jts_pkg::PH_HEX;
                        n_hv    = 8'd0;
                        n_hs    = 3'd0;
                    end else if (esc_hit) begin
                        o_push           = 1'b1;
                        o_res.out_char   = esc_ch;
                        o_res.char_valid = 1'b1;
                        n_cnt            = cnt_inc;
                    end
                end
                jts_pkg::PH_HEX: begin
                    if (b == jts_pkg::CH_NUL) begin
                        // partial value goes out with the end of scan
                        o_push           = 1'b1;
                        o_res.out_char   = hv;
                        o_res.char_valid = 1'b1;
                        o_res.scan_done  = 1'b1;
                        n_phase          = jts_pkg::PH_IDLE;
                    end else begin
                        n_hv = hv_sh;
                        n_hs = hs_inc;
                        if (hs_inc >= 3'd4) begin
                            o_push           = 1'b1;
                            o_res.out_char   = hv_sh;
                            o_res.char_valid = 1'b1;
                            n_cnt            = cnt_inc;
                            n_phase          = jts_pkg::PH_QSTR;
                        end
                    end
                end
                default: begin
                    n_phase = jts_pkg::PH_IDLE;
                end
            endcase
        end
        o_push = o_push && r_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jts_pkg::PH_IDLE;
            r_cnt   <= 6'd0;
            r_hv    <= 8'd0;
            r_hs    <= 3'd0;
        end else if (r_in_valid) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hv    <= n_hv;
            r_hs    <= n_hs;
        end
    end

    assign o_busy = r_in_valid;

    `JTS_ASSERT(a_done_to_idle, (o_push && o_res.scan_done) |=> (r_phase == jts_pkg::PH_IDLE), "scan end did not return to idle")
    `JTS_ASSERT(a_nochar_zero, (o_push && !o_res.char_valid) |-> (o_res.out_char == 8'd0), "char without valid is nonzero")
    `JTS_ASSERT(a_kind_at_done, (o_push && !o_res.scan_done) |-> (o_res.token_kind == 3'd0 && !o_res.end_consumed), "kind or consumed set before scan end")
    `JTS_ASSERT(a_hex_count, (r_hs <= 3'd4), "hex digit count out of range")
endmodule

// ----- hw/rtl/jts_outq.sv -----
// Result queue: registered results toward the master stream, sets input ready.
// Depends on jts_pkg and json_token_scanner_defines.svh.
`include "json_token_scanner_defines.svh"
module jts_outq #(
    parameter int DEPTH = jts_pkg::OQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jts_pkg::t_result  i_res,
    input  logic              i_busy,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output jts_pkg::t_result  o_res
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jts_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // room for the item in flight plus a new one
    assign o_in_ready = ({1'b0, r_count} + (CW + 1)'(i_busy)) < (CW + 1)'(DEPTH);
    assign o_valid    = (r_count != '0);
    assign o_res      = r_mem[r_rd_ptr];

    `JTS_ASSERT(a_no_overflow, (i_push && !pop) |-> (r_count < CW'(DEPTH)), "result queue overflow")
    `JTS_ASSERT_RST(a_reset_empty, !i_rst_n |=> (r_count == '0), "queue not empty after reset")
    `JTS_ASSERT(a_empty_ptrs, (r_count == '0) |-> (r_wr_ptr == r_rd_ptr), "pointers differ while empty")
endmodule

// ----- hw/rtl/json_token_scanner.sv -----
// Top level of the JSON token scanner: APB register, scanner core, result queue.
// Depends on jts_pkg, jts_regs, jts_core and jts_outq.
//
// Scans one JSON-like token per scan from a byte stream, one byte per transfer
// (tuser[0] starts a new scan) and returns decoded characters, with tlast on the
// final result of each scan. The block takes a byte every clock cycle while input
// ready is high; each byte passes an input register, a combinational decode against
// the scan state and the result queue before its result reaches the master side. Bytes
// that give no result (skipped whitespace, escape prefixes, hex digits) produce
// nothing. A queue of OQ_DEPTH results absorbs back-pressure; input ready drops
// only when that queue cannot cover the byte in flight and one more.
// max_length (address 0, reset 64) limits a token to max_length-1 characters, at most 63.
module json_token_scanner #(
    parameter int OQ_DEPTH = jts_pkg::OQ_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] in_byte
    input  logic [0:0]                   s_axis_tuser,  // [0] start_scan
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // [7:0] out_char
    output logic [4:0]                   m_axis_tuser,  // [0] char_valid, [3:1] token_kind,
                                                        // [4] end_consumed
    output logic                         m_axis_tlast,  // scan_done
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jts_pkg::APB_AW-1:0]   paddr,
    input  logic [jts_pkg::APB_DW-1:0]   pwdata,
    output logic [jts_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    logic             max_length_unused;
    logic [6:0]       max_length;
    logic             in_xfer;
    logic             busy;
    logic             push;
    jts_pkg::t_result core_res;
    jts_pkg::t_result q_res;

    assign max_length_unused = 1'b0;

    jts_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (max_length)
    );

    assign in_xfer = s_axis_tvalid && s_axis_tready && !max_length_unused;

    jts_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (max_length),
        .i_in_valid   (in_xfer),
        .i_in_byte    (s_axis_tdata),
        .i_in_start   (s_axis_tuser[0]),
        .o_busy       (busy),
        .o_push       (push),
        .o_res        (core_res)
    );

    jts_outq #(
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (core_res),
        .i_busy     (busy),
        .o_in_ready (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (q_res)
    );

    assign m_axis_tdata = q_res.out_char;
    assign m_axis_tuser = {q_res.end_consumed, q_res.token_kind, q_res.char_valid};
    assign m_axis_tlast = q_res.scan_done;
endmodule

// ----- verif/json_token_scanner_tb.sv -----
// Self-checking testbench for json_token_scanner: random and directed byte streams on the
// slave stream, decoded characters checked on the master stream, max_length set over APB.
// Depends on jts_pkg and the json_token_scanner RTL.
module json_token_scanner_tb;
    import jts_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 160;
    localparam bit [2:0] ADDR_MAX_LENGTH = {REG_MAX_LENGTH, 2'b00};
    localparam bit [7:0] C_0 = 8'h30, C_9 = 8'h39;
    localparam bit [7:0] UC_LO = 8'h41, UC_HI = 8'h4F, LC_LO = 8'h61, LC_HI = 8'h6F;
    localparam bit [7:0] C_FILL = 8'h5F;

    typedef struct packed {
        bit [7:0] data;
        bit       start;
    } t_byte_item;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [7:0] in_byte
    logic [0:0]          s_axis_tuser;   // [0] start_scan
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;   // [7:0] out_char
    logic [4:0]          m_axis_tuser;   // [0] char_valid, [3:1] token_kind, [4] end_consumed
    logic                m_axis_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    json_token_scanner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    t_byte_item text_q[$];
    t_result    decoded_q[$];
    bit         in_xfer;
    bit         lead_start;
    int         n_items;
    int         err_cnt;
    int         cycle_cnt;
    int         tx_idle_pct;
    int         rx_stall_pct;
    bit         hold_req = 1'b0;
    bit         rx_hold = 1'b0;
    bit [6:0]   cfg_plan [7] = '{7'd2, 7'd64, 7'd127, 7'd0, 7'd1, 7'd7, 7'd40};

    // scanner state as the block should hold it
    bit [6:0]   max_len_cfg = MAX_LENGTH_RST;
    logic [2:0] ph = PH_IDLE;
    bit [5:0]   n_chars = '0;
    bit [7:0]   hex_acc = '0;
    bit [2:0]   hex_cnt = '0;

    always #1 i_clk = ~i_clk;

    function automatic void flag_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic bit [5:0] limit_of(bit [6:0] m);
        if (m > 7'd64) return 6'd63;
        if (m == 7'd0) return 6'd0;
        return 6'(m - 7'd1);
    endfunction

    function automatic t_result mk(bit [7:0] ch, bit v, bit d, bit [2:0] k, bit c);
        return t_result'{out_char: ch, char_valid: v, scan_done: d,
                         token_kind: d ? k : 3'd0, end_consumed: d & c};
    endfunction

    function automatic t_result word_step(bit [7:0] b, bit delim, bit [5:0] lim);
        if (delim || n_chars >= lim) return mk(8'd0, 1'b0, 1'b1, KIND_WORD, 1'b0);
        n_chars++;
        ph = PH_WORD;
        return mk(b, 1'b1, n_chars >= lim, KIND_WORD, 1'b1);
    endfunction

    function automatic bit quote_step(bit [7:0] b, bit [5:0] lim, output t_result r);
        ph = PH_QSTR;
        r = '0;
        if (b == CH_QUOTE) begin
            r = mk(8'd0, 1'b0, 1'b1, KIND_QUOTED, 1'b1);
        end else if (b == CH_NUL || n_chars >= lim) begin
            r = mk(8'd0, 1'b0, 1'b1, KIND_QUOTED, 1'b0);
        end else if (b == CH_BSLASH) begin
            ph = PH_ESC;
            return 1'b0;
        end else begin
            n_chars++;
            r = mk(b, 1'b1, 1'b0, KIND_QUOTED, 1'b0);
        end
        return 1'b1;
    endfunction

    // one accepted byte in, at most one decoded result out
    function automatic bit scan_byte(bit [7:0] b, bit st, output t_result r);
        bit       hit;
        bit       delim;
        bit [5:0] lim;
        bit [7:0] ch;
        bit [7:0] dig;
        hit = 1'b1;
        r = '0;
        ch = '0;
        lim = limit_of(max_len_cfg);
        delim = (b <= CH_SPACE) || (b >= CH_HIGH) || b == CH_COMMA
                || b == CH_RBRACKET || b == CH_RBRACE;
        if (st) begin
            ph = PH_SKIP;
            n_chars = '0;
            hex_acc = '0;
            hex_cnt = '0;
        end
        case (ph)
            PH_SKIP: begin
                if (b != CH_NUL && b <= CH_SPACE) hit = 1'b0;
                else if (b == CH_NUL) r = mk(8'd0, 1'b0, 1'b1, KIND_EMPTY, 1'b0);
                else if (b == CH_LBRACE) r = mk(8'd0, 1'b0, 1'b1, KIND_OBJECT, 1'b0);
                else if (b == CH_LBRACKET) r = mk(8'd0, 1'b0, 1'b1, KIND_ARRAY, 1'b0);
                else if (b == CH_QUOTE) begin
                    ph = PH_QFIRST;
                    hit = 1'b0;
                end else r = word_step(b, delim, lim);
            end
            PH_QFIRST: begin
                if (b == CH_LBRACE) r = mk(8'd0, 1'b0, 1'b1, KIND_OBJECT, 1'b0);
                else hit = quote_step(b, lim, r);
            end
            PH_QSTR: hit = quote_step(b, lim, r);
            PH_ESC: begin
                if (b == CH_NUL) begin
                    r = mk(8'd0, 1'b0, 1'b1, KIND_QUOTED, 1'b0);
                end else begin
                    ph = PH_QSTR;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: ch = b;
                        CH_B: ch = CC_BS;
                        CH_F: ch = CC_FF;
                        CH_R: ch = CC_CR;
                        CH_N: ch = CC_LF;
                        CH_T: ch = CC_TAB;
                        CH_U: begin
                            ph = PH_HEX;
                            hex_acc = '0;
                            hex_cnt = '0;
                            hit = 1'b0;
                        end
                        default: hit = 1'b0;
                    endcase
                    if (hit) begin
                        n_chars++;
                        r = mk(ch, 1'b1, 1'b0, KIND_QUOTED, 1'b0);
                    end
                end
            end
            PH_HEX: begin
                if (b == CH_NUL) begin
                    r = mk(hex_acc, 1'b1, 1'b1, KIND_QUOTED, 1'b0);
                end else begin
                    if (b >= C_0 && b <= C_9) dig = {4'h0, b[3:0]};
                    else if ((b >= UC_LO && b <= UC_HI) || (b >= LC_LO && b <= LC_HI))
                        dig = 8'd9 + {4'h0, b[3:0]};
                    else dig = 8'd0;
                    hex_acc = {hex_acc[3:0], 4'h0} + dig;
                    hex_cnt++;
                    if (hex_cnt >= 3'd4) begin
                        ph = PH_QSTR;
                        n_chars++;
                        r = mk(hex_acc, 1'b1, 1'b0, KIND_QUOTED, 1'b0);
                    end else hit = 1'b0;
                end
            end
            PH_WORD: r = word_step(b, delim, lim);
            default: begin
                ph = PH_IDLE;
                hit = 1'b0;
            end
        endcase
        if (hit && r.scan_done) ph = PH_IDLE;
        return hit;
    endfunction

    // ---- stimulus ----
    function automatic void put_byte(bit [7:0] b);
        text_q.push_back(t_byte_item'{data: b, start: lead_start});
        lead_start = 1'b0;
        n_items++;
    endfunction

    function automatic bit [7:0] hex_char();
        case ($urandom_range(3))
            0: return C_0 + 8'($urandom_range(9));
            1: return UC_LO + 8'($urandom_range(14));
            2: return LC_LO + 8'($urandom_range(14));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic bit [7:0] text_char();
        bit [7:0] c;
        if ($urandom_range(3) == 0) c = 8'($urandom_range(1, 255));
        else c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_QUOTE || c == CH_BSLASH) c = C_FILL;
        return c;
    endfunction

    function automatic bit [7:0] esc_char();
        case ($urandom_range(9))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_R;
            6: return CH_N;
            7: return CH_T;
            8: return CH_U;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic bit [7:0] word_char();
        bit [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7F));
        if (c == CH_QUOTE || c == CH_LBRACE || c == CH_LBRACKET || c == CH_COMMA
            || c == CH_RBRACKET || c == CH_RBRACE) c = C_FILL;
        return c;
    endfunction

    function automatic void gen_token();
        int       r;
        int       n;
        bit [7:0] c;
        lead_start = 1'b1;
        repeat ($urandom_range(2)) put_byte(8'($urandom_range(1, 32)));
        r = $urandom_range(99);
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(8);
        if (r < 40) begin
            put_byte(CH_QUOTE);
            repeat (n) begin
                if ($urandom_range(4) == 0) begin
                    put_byte(CH_BSLASH);
                    c = esc_char();
                    put_byte(c);
                    if (c == CH_U) repeat (4) put_byte(hex_char());
                end else begin
                    put_byte(text_char());
                end
            end
            case ($urandom_range(9))
                6: put_byte(CH_NUL);
                7: begin
                    put_byte(CH_BSLASH);
                    put_byte(CH_NUL);
                end
                8: begin
                    put_byte(CH_BSLASH);
                    put_byte(CH_U);
                    repeat ($urandom_range(3)) put_byte(hex_char());
                    put_byte(CH_NUL);
                end
                9: ;
                default: put_byte(CH_QUOTE);
            endcase
        end else if (r < 65) begin
            repeat (n) put_byte(word_char());
            case ($urandom_range(5))
                0: put_byte(8'($urandom_range(32)));
                1: put_byte(8'($urandom_range(128, 255)));
                2: put_byte(CH_COMMA);
                3: put_byte(CH_RBRACKET);
                4: put_byte(CH_RBRACE);
                default: ;
            endcase
        end else if (r < 72) begin
            put_byte(CH_LBRACE);
        end else if (r < 76) begin
            put_byte(CH_QUOTE);
            put_byte(CH_LBRACE);
        end else if (r < 82) begin
            put_byte(CH_LBRACKET);
        end else if (r < 86) begin
            put_byte(CH_NUL);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                lead_start = 1'($urandom_range(1));
                put_byte(8'($urandom_range(255)));
            end
        end
        // trailing bytes without a start, mostly ignored
        if ($urandom_range(6) == 0)
            text_q.push_back(t_byte_item'{data: 8'($urandom_range(255)), start: 1'b0});
    endfunction

    task automatic drain();
        while (text_q.size() != 0 || s_axis_tvalid || hold_req || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_length(bit [6:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_LENGTH;
        pwdata  <= {25'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        max_len_cfg = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {25'd0, v})
            flag_mismatch($sformatf("max_length read exp=%0d got=%0h", v, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---- sender and receiver ----
    always @(negedge i_clk) begin : driver
        t_byte_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else if (!s_axis_tvalid || in_xfer) begin
            if (text_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = text_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data;
                s_axis_tuser  <= nxt.start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    always begin
        wait (hold_req);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
        hold_req = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_result pred;
        t_result want;
        t_result seen;
        in_xfer = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_xfer = 1'b1;
                if (scan_byte(s_axis_tdata, s_axis_tuser[0], pred)) decoded_q.push_back(pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = t_result'{out_char: m_axis_tdata, char_valid: m_axis_tuser[0],
                                 scan_done: m_axis_tlast, token_kind: m_axis_tuser[3:1],
                                 end_consumed: m_axis_tuser[4]};
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result char=%02h valid=%b last=%b kind=%0d cons=%b",
                        seen.out_char, seen.char_valid, seen.scan_done, seen.token_kind,
                        seen.end_consumed));
                end else begin
                    want = decoded_q.pop_front();
                    if (seen !== want)
                        flag_mismatch($sformatf({"exp char=%02h valid=%b last=%b kind=%0d cons=%b",
                            " | got char=%02h valid=%b last=%b kind=%0d cons=%b"},
                            want.out_char, want.char_valid, want.scan_done, want.token_kind,
                            want.end_consumed, seen.out_char, seen.char_valid, seen.scan_done,
                            seen.token_kind, seen.end_consumed));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("json_token_scanner_tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each token kind and the odd endings, reset length
        lead_start = 1'b1; put_byte(CH_NUL);
        lead_start = 1'b1; put_byte(CH_SPACE); put_byte(8'h01); put_byte(CH_LBRACE);
        lead_start = 1'b1; put_byte(CH_QUOTE); put_byte(CH_LBRACE);
        lead_start = 1'b1; put_byte(CH_LBRACKET);
        lead_start = 1'b1; put_byte("a"); put_byte(8'h7F); put_byte(CH_COMMA);
        text_q.push_back(t_byte_item'{data: 8'h41, start: 1'b0});
        lead_start = 1'b1; put_byte("z"); put_byte(8'hFF);
        lead_start = 1'b1; put_byte(CH_RBRACE);
        lead_start = 1'b1; put_byte(CH_QUOTE); put_byte(CH_BSLASH); put_byte(CH_N);
        put_byte(CH_BSLASH); put_byte(CH_U); put_byte("4"); put_byte("1"); put_byte("f");
        put_byte("F"); put_byte(CH_BSLASH); put_byte("q"); put_byte(CH_QUOTE);
        lead_start = 1'b1; put_byte(CH_QUOTE); put_byte("k");
        lead_start = 1'b1; put_byte(CH_QUOTE); put_byte(CH_BSLASH); put_byte(CH_NUL);
        lead_start = 1'b1; put_byte(CH_QUOTE); put_byte(CH_BSLASH); put_byte(CH_U);
        put_byte("7"); put_byte(CH_NUL);

        foreach (cfg_plan[i]) begin
            drain();
            set_max_length(cfg_plan[i]);
            tx_idle_pct  = (i == 1) ? 0 : 35;
            rx_stall_pct = (i == 1) ? 0 : 35;
            if (i == 1) hold_req = 1'b1;
            n_items = 0;
            while (n_items < ITEMS_PER_PHASE) gen_token();
        end
        drain();

        if (err_cnt == 0) begin
            $display("json_token_scanner_tb: PASS");
        end else begin
            $display("json_token_scanner_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/jts_pkg.sv
hw/rtl/jts_regs.sv
hw/rtl/jts_core.sv
hw/rtl/jts_outq.sv
hw/rtl/json_token_scanner.sv
verif/json_token_scanner_tb.sv
